[rtl/bitmap_page_allocator_unit_assert.svh]
// Assertion macros for the bitmap page allocator.
// Used by bitmap_page_allocator_unit.sv; no other dependencies.
`ifndef BITMAP_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define BPA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bitmap page allocator assertion failed");
// next-cycle implication
`define BPA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bitmap page allocator assertion failed");
`else
`define BPA_ASSERT_IMP(label, clk, rst, ante, cons)
`define BPA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/bpa_pkg.sv]
// Types and constants for the bitmap page allocator.
// Used by bitmap_page_allocator_unit.sv; no dependencies.
package bpa_pkg;

  // command opcodes
  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_MFREE = 3'd2,
    OP_MUSED = 3'd3,
    OP_INIT  = 3'd4
  } op_t;

  // result status codes
  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_ZERO_COUNT = 3'd1;
  localparam logic [2:0] STAT_TOO_FEW    = 3'd2;
  localparam logic [2:0] STAT_NOT_FOUND  = 3'd3;
  localparam logic [2:0] STAT_MISALIGNED = 3'd4;
  localparam logic [2:0] STAT_RANGE      = 3'd5;
  localparam logic [2:0] STAT_DOUBLE     = 3'd6;
  localparam logic [2:0] STAT_IGNORED    = 3'd7;

  // configuration register indexes
  localparam logic [1:0] REG_NUM_PAGES   = 2'd0;
  localparam logic [1:0] REG_MEM_TOP     = 2'd1;
  localparam logic [1:0] REG_AVAIL_PAGES = 2'd2;

  localparam int          PAGE_SHIFT    = 12;
  localparam int          MAP_WORD_BITS = 32;
  localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_SRD, S_SEVAL, S_BRD, S_BLD, S_BIT, S_BWB, S_DONE
  } state_t;

  // bit walker modes
  typedef enum logic [1:0] {
    MODE_RUN, MODE_CHECK, MODE_WRITE
  } mode_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] byte_address;
    logic [31:0] byte_size;
    logic [16:0] pg_count;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] alloc_address;
    logic [16:0] free_count;
    logic [31:0] used_count;
  } result_t;

  // index of lowest zero bit; 31 when none
  function automatic logic [4:0] first_zero(input logic [31:0] bits);
    logic [4:0] idx;
    idx = 5'd31;
    for (int i = 31; i >= 0; i--) begin
      if (!bits[i]) idx = 5'(i);
    end
    return idx;
  endfunction

endpackage

[rtl/bitmap_page_allocator_unit.sv]
// Bitmap physical page allocator, top level with the used-page bitmap memory.
// Depends on bpa_pkg and bitmap_page_allocator_unit_assert.svh.
//
// Commands enter on cmd, taken when start is high and busy is low. One result
// per command appears on result, marked by done for one cycle; the receiver
// cannot stall it. Configuration writes (cfg_valid/cfg_index/cfg_data) are
// always taken (cfg_ready is tied high) and belong to idle periods.
// Steps from accept to done, shaped by one bitmap read port and a one-bit walker:
//   errors found up front, unknown opcodes, empty mark ranges: decode, then done.
//   other items: decode, their walk as below, then done.
//   single-page alloc: read and evaluate states per bitmap word scanned, a wrap
//     state back to word 0, then read, load, bit, write-back to set the page.
//   multi-page alloc, free, mark: one page per cycle in the bit state, a read and
//     a load state per word read, a write-back state per word written; free walks
//     its range twice (check, clear).
//   init: a sweep of every bitmap word (MAX_PAGES/32, 2048 by default).
// A new item is taken during the done cycle; items do not overlap.
// After reset the bitmap is swept to all-used, one word a cycle, with busy
// high; configuration writes are taken meanwhile.
module bitmap_page_allocator_unit
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd,
  output logic        done,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [16:0] TP_LIMIT = 17'((MAX_PAGES > 131071) ? 131071 : MAX_PAGES);
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  // configuration
  logic [16:0] num_pages, avail_pages;
  logic [31:0] mem_top;

  // control and state
  state_t      state, state_next;
  mode_t       mode, mode_next;
  cmd_t        cmd_q;
  logic [16:0] hint, hint_next;
  logic [16:0] free_cnt, free_cnt_next;
  logic [31:0] used_cnt, used_cnt_next;
  logic [AW-1:0] clr_idx, clr_idx_next;
  logic        from_init, from_init_next;
  logic [12:0] w, w_next;
  logic        pass2, pass2_next;
  logic [16:0] pg, pg_next, pend, pend_next;
  logic [16:0] run, run_next, first, first_next;
  logic        wval, wval_next;
  logic [31:0] wbuf, wbuf_next;
  logic [11:0] wword, wword_next;
  logic [2:0]  res_status, res_status_next;
  logic [31:0] res_addr, res_addr_next;
  logic        done_next;
  result_t     result_next;

  // bitmap memory
  logic [31:0]   map_mem [MAP_WORDS];
  logic [31:0]   rd_data;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [31:0]   wdata;

  // derived values
  logic [16:0] tp;
  logic [12:0] words;
  logic [11:0] start_w;
  logic [31:0] lowm, sbits, e_sum;
  logic [4:0]  fz;
  logic [16:0] pgw, pg_inc, run_inc, first_eff, e_clip;
  logic [19:0] s_pg, e_pg, a_pg;
  logic        is_start, bitv;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_pages   <= 17'd65536;
      mem_top     <= 32'd268435456;
      avail_pages <= 17'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NUM_PAGES:   num_pages   <= cfg_data[16:0];
        REG_MEM_TOP:     mem_top     <= cfg_data;
        REG_AVAIL_PAGES: avail_pages <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // bitmap memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) map_mem[waddr] <= wdata;
    rd_data <= map_mem[raddr];
  end

  // effective page count and search helpers
  always_comb begin
    tp        = (num_pages > TP_LIMIT) ? TP_LIMIT : num_pages;
    words     = 13'((18'(tp) + 18'd31) >> 5);
    start_w   = hint[16:5];
    is_start  = (w[11:0] == start_w);
    lowm      = (32'd1 << hint[4:0]) - 32'd1;
    if (!pass2) sbits = rd_data | (is_start ? lowm : 32'd0);
    else        sbits = rd_data | (is_start ? ~lowm : 32'd0);
    fz        = first_zero(sbits);
    pgw       = {w[11:0], fz};
    bitv      = wbuf[pg[4:0]];
    pg_inc    = pg + 17'd1;
    run_inc   = run + 17'd1;
    first_eff = (run == 17'd0) ? pg : first;
    a_pg      = cmd_q.byte_address[31:12];
    s_pg      = cmd_q.byte_address[31:12];
    e_sum     = cmd_q.byte_address + cmd_q.byte_size + 32'd4095;
    e_pg      = e_sum[31:12];
    e_clip    = (e_pg > {3'd0, tp}) ? tp : e_pg[16:0];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      from_init <= 1'b0;
      hint      <= '0;
      free_cnt  <= '0;
      used_cnt  <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      from_init <= from_init_next;
      hint      <= hint_next;
      free_cnt  <= free_cnt_next;
      used_cnt  <= used_cnt_next;
      done      <= done_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start && !busy) cmd_q <= cmd;
    mode       <= mode_next;
    w          <= w_next;
    pass2      <= pass2_next;
    pg         <= pg_next;
    pend       <= pend_next;
    run        <= run_next;
    first      <= first_next;
    wval       <= wval_next;
    wbuf       <= wbuf_next;
    wword      <= wword_next;
    res_status <= res_status_next;
    res_addr   <= res_addr_next;
    result     <= result_next;
  end

  // sequencer
  always_comb begin
    state_next      = state;
    mode_next       = mode;
    clr_idx_next    = clr_idx;
    from_init_next  = from_init;
    hint_next       = hint;
    free_cnt_next   = free_cnt;
    used_cnt_next   = used_cnt;
    w_next          = w;
    pass2_next      = pass2;
    pg_next         = pg;
    pend_next       = pend;
    run_next        = run;
    first_next      = first;
    wval_next       = wval;
    wbuf_next       = wbuf;
    wword_next      = wword;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    result_next     = result;
    done_next       = 1'b0;
    we              = 1'b0;
    waddr           = clr_idx;
    wdata           = ALL_ONES;
    raddr           = AW'(pg[16:5]);

    case (state)
      // sweep the bitmap to all used
      S_CLEAR: begin
        we           = 1'b1;
        clr_idx_next = clr_idx + AW'(1);
        if (clr_idx == LAST_WORD) begin
          clr_idx_next = '0;
          if (from_init) begin
            from_init_next  = 1'b0;
            res_status_next = STAT_OK;
            res_addr_next   = '0;
            state_next      = S_DONE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end

      // up-front checks and setup per opcode
      S_DECODE: begin
        res_addr_next = '0;
        state_next    = S_DONE;
        case (cmd_q.opcode)
          OP_ALLOC: begin
            if (cmd_q.pg_count == 17'd0) begin
              res_status_next = STAT_ZERO_COUNT;
            end else if (cmd_q.pg_count > free_cnt) begin
              res_status_next = STAT_TOO_FEW;
            end else if (cmd_q.pg_count == 17'd1) begin
              if (hint >= tp) hint_next = '0;
              pass2_next = 1'b0;
              w_next     = {1'b0, ((hint >= tp) ? 12'd0 : hint[16:5])};
              state_next = S_SRD;
            end else begin
              pg_next   = '0;
              pend_next = tp;
              run_next  = '0;
              first_next = '0;
              mode_next = MODE_RUN;
              if (tp == 17'd0) res_status_next = STAT_NOT_FOUND;
              else             state_next = S_BRD;
            end
          end
          OP_FREE: begin
            if (cmd_q.pg_count == 17'd0) begin
              res_status_next = STAT_ZERO_COUNT;
            end else if (cmd_q.byte_address[11:0] != 12'd0) begin
              res_status_next = STAT_MISALIGNED;
            end else if (a_pg >= {3'd0, tp} || cmd_q.pg_count > tp - a_pg[16:0]) begin
              res_status_next = STAT_RANGE;
            end else begin
              pg_next    = a_pg[16:0];
              first_next = a_pg[16:0];
              pend_next  = a_pg[16:0] + cmd_q.pg_count;
              mode_next  = MODE_CHECK;
              state_next = S_BRD;
            end
          end
          OP_MFREE, OP_MUSED: begin
            if (cmd_q.byte_address > mem_top) begin
              res_status_next = STAT_IGNORED;
            end else if (s_pg >= {3'd0, e_clip}) begin
              res_status_next = STAT_OK;
            end else begin
              pg_next    = s_pg[16:0];
              pend_next  = e_clip;
              wval_next  = (cmd_q.opcode == OP_MUSED);
              mode_next  = MODE_WRITE;
              state_next = S_BRD;
            end
          end
          OP_INIT: begin
            free_cnt_next  = '0;
            used_cnt_next  = {15'd0, avail_pages};
            hint_next      = '0;
            clr_idx_next   = '0;
            from_init_next = 1'b1;
            state_next     = S_CLEAR;
          end
          default: res_status_next = STAT_IGNORED;
        endcase
      end

      // next-fit: issue word read, or wrap to the second pass
      S_SRD: begin
        raddr = AW'(w[11:0]);
        if (!pass2 && w >= words) begin
          pass2_next = 1'b1;
          w_next     = '0;
        end else begin
          state_next = S_SEVAL;
        end
      end

      // next-fit: look for a free page in the masked word
      S_SEVAL: begin
        if (sbits == ALL_ONES) begin
          if (pass2 && is_start) begin
            res_status_next = STAT_NOT_FOUND;
            res_addr_next   = '0;
            state_next      = S_DONE;
          end else begin
            w_next     = w + 13'd1;
            state_next = S_SRD;
          end
        end else if (pgw >= tp) begin
          if (pass2) begin
            res_status_next = STAT_NOT_FOUND;
            res_addr_next   = '0;
            state_next      = S_DONE;
          end else begin
            pass2_next = 1'b1;
            w_next     = '0;
            state_next = S_SRD;
          end
        end else begin
          pg_next    = pgw;
          first_next = pgw;
          pend_next  = pgw + 17'd1;
          wval_next  = 1'b1;
          mode_next  = MODE_WRITE;
          state_next = S_BRD;
        end
      end

      // bit walker: read the word holding pg
      S_BRD: begin
        state_next = S_BLD;
      end

      S_BLD: begin
        wbuf_next  = rd_data;
        wword_next = pg[16:5];
        state_next = S_BIT;
      end

      // bit walker: one page per cycle until a word boundary or the range end
      S_BIT: begin
        pg_next = pg_inc;
        case (mode)
          MODE_RUN: begin
            if (bitv) begin
              run_next = '0;
            end else begin
              first_next = first_eff;
              run_next   = run_inc;
            end
            if (!bitv && run_inc == cmd_q.pg_count) begin
              if (first_eff == 17'd0) begin
                res_status_next = STAT_NOT_FOUND;
                res_addr_next   = '0;
                state_next      = S_DONE;
              end else begin
                pg_next    = first_eff;
                pend_next  = first_eff + cmd_q.pg_count;
                wval_next  = 1'b1;
                mode_next  = MODE_WRITE;
                state_next = S_BRD;
              end
            end else if (pg_inc == pend) begin
              res_status_next = STAT_NOT_FOUND;
              res_addr_next   = '0;
              state_next      = S_DONE;
            end else if (pg[4:0] == 5'd31) begin
              state_next = S_BRD;
            end
          end
          MODE_CHECK: begin
            if (!bitv) begin
              res_status_next = STAT_DOUBLE;
              res_addr_next   = '0;
              state_next      = S_DONE;
            end else if (pg_inc == pend) begin
              pg_next    = first;
              wval_next  = 1'b0;
              mode_next  = MODE_WRITE;
              state_next = S_BRD;
            end else if (pg[4:0] == 5'd31) begin
              state_next = S_BRD;
            end
          end
          MODE_WRITE: begin
            if (bitv != wval) begin
              wbuf_next[pg[4:0]] = wval;
              if (wval) begin
                free_cnt_next = free_cnt - 17'd1;
                used_cnt_next = used_cnt + 32'd1;
              end else begin
                free_cnt_next = free_cnt + 17'd1;
                used_cnt_next = used_cnt - 32'd1;
              end
            end
            if (pg_inc == pend || pg[4:0] == 5'd31) state_next = S_BWB;
          end
          default: state_next = S_IDLE;
        endcase
      end

      // bit walker: write the word back
      S_BWB: begin
        we    = 1'b1;
        waddr = AW'(wword);
        wdata = wbuf;
        if (pg == pend) begin
          res_status_next = STAT_OK;
          res_addr_next   = '0;
          if (cmd_q.opcode == OP_ALLOC) begin
            res_addr_next = 32'(first) << PAGE_SHIFT;
            if (cmd_q.pg_count == 17'd1) hint_next = (pg >= tp) ? 17'd0 : pg;
          end
          state_next = S_DONE;
        end else begin
          state_next = S_BRD;
        end
      end

      // register the result and raise done for one cycle
      S_DONE: begin
        done_next                 = 1'b1;
        result_next.status        = res_status;
        result_next.alloc_address = res_addr;
        result_next.free_count    = free_cnt;
        result_next.used_count    = used_cnt;
        state_next                = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

`include "bitmap_page_allocator_unit_assert.svh"

  // a result never overlaps work in progress
  `BPA_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  // an accepted item blocks new ones and cannot finish in the next cycle
  `BPA_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy && !done)
  // only a successful alloc reports an address
  `BPA_ASSERT_IMP(a_addr_ok, clk, rst, done && result.alloc_address != 32'd0,
                  result.status == STAT_OK && cmd_q.opcode == OP_ALLOC)
  // reported addresses are page aligned
  `BPA_ASSERT_IMP(a_addr_align, clk, rst, done, result.alloc_address[11:0] == 12'd0)

endmodule
